/* hdl/sha1bc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_pkg
// Shared types, constants and helper functions of the SHA-1 block compressor.
// ----------------------------------------------------------------------------
package sha1bc_pkg;

  localparam int WordW      = 32;
  localparam int DigestN    = 5;
  localparam int BlockWords = 16;
  localparam int Rounds     = 80;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);
  localparam int PosW       = $clog2(BlockWords);
  localparam int RndW       = $clog2(Rounds);

  localparam logic [PosW-1:0] PosLast  = PosW'(BlockWords - 1);
  localparam logic [RndW-1:0] RndLast  = RndW'(Rounds - 1);
  localparam logic [RndW-1:0] RndPhase1 = RndW'(20);
  localparam logic [RndW-1:0] RndPhase2 = RndW'(40);
  localparam logic [RndW-1:0] RndPhase3 = RndW'(60);

  // Initial chaining value, entry 0 is h0.
  localparam logic [DigestN-1:0][WordW-1:0] HInit = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  // One message word as it sits in the queue between front and back.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             start;
    logic             last;
  } qword_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] x);
    return {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] x);
    return {x[WordW-6:0], x[WordW-1:WordW-5]};
  endfunction

  function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] x);
    return {x[1:0], x[WordW-1:2]};
  endfunction

endpackage

/* hdl/sha1bc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_front
// Accepts message words, tracks the position inside the block and tags each
// word with its start and end-of-block flags before it enters the queue.
// ----------------------------------------------------------------------------
module sha1bc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sha1bc_pkg::WordW-1:0]      in_tdata,
  input  logic                              in_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output sha1bc_pkg::qword_t                q_entry
);

  logic [sha1bc_pkg::PosW-1:0] pos_r;
  logic [sha1bc_pkg::PosW-1:0] pos_nxt;
  logic [sha1bc_pkg::PosW-1:0] pos_eff;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // A start beat always lands as word 0 of a fresh block.
  assign pos_eff = in_tuser ? '0 : pos_r;
  assign pos_nxt = pos_eff + sha1bc_pkg::PosW'(1);

  assign q_entry.word  = in_tdata;
  assign q_entry.start = in_tuser;
  assign q_entry.last  = (pos_eff == sha1bc_pkg::PosLast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* hdl/sha1bc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_fifo
// Short first-word-fall-through queue of tagged message words.
// ----------------------------------------------------------------------------
module sha1bc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sha1bc_pkg::qword_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output sha1bc_pkg::qword_t head
);

  sha1bc_pkg::qword_t              slot_r [sha1bc_pkg::QDepth];
  logic [sha1bc_pkg::QPtrW-1:0]    wr_ptr_r;
  logic [sha1bc_pkg::QPtrW-1:0]    rd_ptr_r;
  logic [sha1bc_pkg::QCntW-1:0]    count_r;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count_r == sha1bc_pkg::QCntW'(sha1bc_pkg::QDepth));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + sha1bc_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + sha1bc_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + sha1bc_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - sha1bc_pkg::QCntW'(1);
      end
    end
  end

endmodule

/* hdl/sha1bc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_core
// Loads a block into the 16-word schedule window, runs the 80 rounds one per
// cycle and folds the result into the chaining value and the output register.
// ----------------------------------------------------------------------------
module sha1bc_core (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           q_valid,
  input  sha1bc_pkg::qword_t                             q_head,
  output logic                                           q_pop,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  output logic [sha1bc_pkg::DigestN*sha1bc_pkg::WordW-1:0] out_tdata
);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_ROUND   = 2'd1;
  localparam logic [1:0] ST_FINISH  = 2'd2;

  logic [1:0]                                      state_r;
  logic [sha1bc_pkg::RndW-1:0]                     rnd_r;
  logic [sha1bc_pkg::WordW-1:0]                    w_r [sha1bc_pkg::BlockWords];
  logic [sha1bc_pkg::DigestN-1:0][sha1bc_pkg::WordW-1:0] h_r;
  logic [sha1bc_pkg::WordW-1:0]                    a_r, b_r, c_r, d_r, e_r;
  logic                                            out_valid_r;
  logic [sha1bc_pkg::DigestN-1:0][sha1bc_pkg::WordW-1:0] out_data_r;

  logic [sha1bc_pkg::WordW-1:0]                    f_val;
  logic [sha1bc_pkg::WordW-1:0]                    k_val;
  logic [sha1bc_pkg::WordW-1:0]                    t_val;
  logic [sha1bc_pkg::WordW-1:0]                    w_new;
  logic [sha1bc_pkg::DigestN-1:0][sha1bc_pkg::WordW-1:0] h_sum;
  logic                                            finish_go;

  assign q_pop      = q_valid && (state_r == ST_COLLECT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign finish_go  = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  always_comb begin
    if (rnd_r < sha1bc_pkg::RndPhase1) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1bc_pkg::K0;
    end else if (rnd_r < sha1bc_pkg::RndPhase2) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1bc_pkg::K1;
    end else if (rnd_r < sha1bc_pkg::RndPhase3) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1bc_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1bc_pkg::K3;
    end
    t_val = sha1bc_pkg::rotl5(a_r) + f_val + e_r + w_r[0] + k_val;
    // w_r[0] is the current schedule word; the window slides by one a round.
    w_new = sha1bc_pkg::rotl1(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]);
    h_sum[0] = h_r[0] + a_r;
    h_sum[1] = h_r[1] + b_r;
    h_sum[2] = h_r[2] + c_r;
    h_sum[3] = h_r[3] + d_r;
    h_sum[4] = h_r[4] + e_r;
  end

  // Schedule window, working variables and the digest output register.
  always_ff @(posedge clk) begin
    if (q_pop || (state_r == ST_ROUND)) begin
      for (int i = 0; i < sha1bc_pkg::BlockWords - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[sha1bc_pkg::BlockWords-1] <= q_pop ? q_head.word : w_new;
    end
    if (q_pop && q_head.last) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (state_r == ST_ROUND) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= sha1bc_pkg::rotl30(b_r);
      d_r <= c_r;
      e_r <= d_r;
    end
    if (finish_go) begin
      out_data_r <= h_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      rnd_r       <= '0;
      h_r         <= sha1bc_pkg::HInit;
      out_valid_r <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_COLLECT: begin
          if (q_pop) begin
            if (q_head.start) begin
              h_r <= sha1bc_pkg::HInit;
            end
            if (q_head.last) begin
              rnd_r   <= '0;
              state_r <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + sha1bc_pkg::RndW'(1);
          if (rnd_r == sha1bc_pkg::RndLast) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            h_r     <= h_sum;
            state_r <= ST_COLLECT;
          end
        end
        default: begin
          state_r <= ST_COLLECT;
        end
      endcase
    end
  end

endmodule

/* hdl/sha1_block_compress_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_block_compress_top
// SHA-1 compression of a padded message fed as 32-bit big-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one message word in in_tdata; in_tuser is high on the
//   first word of a message, which reloads the initial hash value and starts
//   a new block (a partly collected block is dropped). Every sixteenth word
//   of a block triggers the 80 rounds.
//   One output beat per block carries the running digest h0..h4.
//   Words first enter a four-deep queue, so the sender keeps streaming while
//   a block is compressed; in_tready drops only when that queue is full.
//   Sequence: the back end loads the schedule window word by word, runs
//   the 80 rounds (one round unit, one round a cycle) and then folds the
//   chaining value into the digest; out_tvalid rises with that fold.
//   The digest sits in an output register; while it waits, the next block
//   is loaded and compressed, and the back end holds only at the final fold
//   until the previous digest has been taken.
//   Reset (synchronous, active low) empties the queue, restores the initial
//   hash value and clears out_tvalid.
// ----------------------------------------------------------------------------
module sha1_block_compress_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] word
  input  logic         in_tuser,   // [0] starts_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata   // [31:0] digest_0 .. [159:128] digest_4
);

  sha1bc_pkg::qword_t q_in;
  sha1bc_pkg::qword_t q_head;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;

  sha1bc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  sha1bc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  sha1bc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* hdl/sha1bc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1bc_checker
// Port-level checks of the SHA-1 block compressor, bound to the top level.
// ----------------------------------------------------------------------------
module sha1bc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata
);

  // A digest beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before the beat was taken");

  // The digest of a stalled beat does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while the beat was stalled");

  // Reset leaves no digest pending.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Reset empties the word queue, so the input side is ready right away.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("in_tready low after reset");

endmodule

bind sha1_block_compress_top sha1bc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the SHA-1 block compressor.
// ----------------------------------------------------------------------------
// Message words are streamed into the block while a scoreboard keeps its own
// SHA-1 chaining state. Each accepted word is stored in its block. The word that
// completes a block queues the expected digest, and every digest beat that
// comes out is compared word by word against the oldest queued one. The test
// starts with a short directed prologue. A random run follows that mixes
// well-formed multi-block messages, messages cut short by a new start flag,
// and noise. Both sides idle at random, with one quiet stretch. The sink also
// holds off once for a long time so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          NumWords   = 900;
  localparam logic [3:0]  LastInBlk  = 4'd15;
  localparam int          HoldCycles = 1000;

  class sha1_scoreboard;
    logic [31:0]  chain [5];
    logic [31:0]  blk [16];
    logic [3:0]   pos;
    logic [159:0] digest_q [$];
    int           errors;

    function new();
      load_iv();
      foreach (blk[i]) blk[i] = '0;
      pos    = '0;
      errors = 0;
    endfunction

    function void load_iv();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      chain[4] = 32'hc3d2e1f0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // Expands the schedule and runs the 80 rounds on the collected block.
    function void compress();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) sched[i] = blk[i];
      for (int i = 16; i < 80; i++)
        sched[i] = rol(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = rol(a, 5) + f + e + sched[i] + k;
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void note_word(logic [31:0] w, logic s);
      // A start flag restarts the message and drops any partial block.
      if (s) begin
        load_iv();
        pos = '0;
      end
      blk[pos] = w;
      if (pos != LastInBlk) begin
        pos = pos + 1'b1;
      end else begin
        pos = '0;
        compress();
        digest_q.push_back({chain[4], chain[3], chain[2], chain[1], chain[0]});
      end
    endfunction

    function void check_digest(logic [159:0] got);
      logic [159:0] want;
      if (digest_q.size() == 0) begin
        $error("digest beat with no block pending: %h", got);
        errors++;
        return;
      end
      want = digest_q.pop_front();
      for (int i = 0; i < 5; i++) begin
        if (got[32*i +: 32] !== want[32*i +: 32]) begin
          $error("digest_%0d mismatch: expected %h, actual %h",
                 i, want[32*i +: 32], got[32*i +: 32]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;   // [31:0] word
  logic         in_tuser   = 1'b0; // [0] starts_message
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;         // [31:0] digest_0 .. [159:128] digest_4

  sha1_scoreboard sb;
  int             sent     = 0;
  bit             quiet    = 1'b1;
  bit             hold_req = 1'b0;

  always #4 clk = ~clk;

  sha1_block_compress_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // Offers one word and returns once its beat has been taken.
  task automatic send_word(logic [31:0] w, logic s);
    while (!quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_word(w, s);
    sent++;
  endtask

  task automatic send_message(int nwords, bit with_start);
    for (int i = 0; i < nwords; i++) send_word(pick_word(), with_start && i == 0);
  endtask

  task automatic wait_digests_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Sink side: checks digest beats and decides out_tready for the next cycle.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_digest(out_tdata);
      if (hold_req) begin
        hold_cnt = HoldCycles;
        hold_req = 1'b0;
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    logic [31:0] pattern [16];
    bit          held;
    bit          paused;
    int          r;
    sb     = new();
    held   = 1'b0;
    paused = 1'b0;
    pattern = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0000,
                32'h6162_6380, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE,
                32'h0123_4567, 32'h89AB_CDEF, 32'hFFFF_FFFF, 32'h0000_0018};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Words right after reset without a start flag, then a start flag that
    // drops that partial block and a full block of extreme words.
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    for (int i = 0; i < 16; i++) send_word(pattern[i], i == 0);
    in_tvalid <= 1'b0;
    wait_digests_drained();

    quiet = 1'b0;
    while (sent < NumWords) begin
      if (!held && sent >= 250) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      quiet = (sent >= 450 && sent < 600);
      if (!paused && sent >= 700) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        wait_digests_drained();
        @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 75) begin
        send_message(16 * $urandom_range(1, 3), 1'b1);
      end else if (r < 90) begin
        send_message($urandom_range(1, 15), 1'b1);
      end else begin
        for (int i = $urandom_range(1, 20); i > 0; i--)
          send_word(pick_word(), $urandom_range(9) == 0);
      end
    end
    in_tvalid <= 1'b0;

    wait_digests_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
